// ===== src/aliquot_perfect_amicable_check_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the aliquot sum check
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ALIQUOT_PERFECT_AMICABLE_CHECK_ASSERT_SVH
`define ALIQUOT_PERFECT_AMICABLE_CHECK_ASSERT_SVH

`ifndef SYNTH
`define APAC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apac assertion failed");
`define APAC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apac assertion failed");
`else
`define APAC_ASSERT_IMP(name, ante, cons)
`define APAC_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== src/apac_pkg.sv =====
// ----------------------------------------------------------------------------
// apac_pkg
// Widths, state types and status struct of the aliquot sum check.
// ----------------------------------------------------------------------------
package apac_pkg;

  localparam int NUM_W = 32;
  localparam int SUM_W = 35;
  localparam int DIV_W = 17;
  localparam int CNT_W = $clog2(NUM_W + 1);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [2:0] {
    SU_IDLE,
    SU_LAUNCH,
    SU_DIV,
    SU_ADDQ,
    SU_FIN
  } sum_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_PASS1,
    T_PASS2,
    T_DONE
  } top_state_t;

endpackage

// ===== src/apac_div.sv =====
// ----------------------------------------------------------------------------
// apac_div
// Bit-serial restoring divider: one quotient bit per cycle, NUM_W quotient bits.
// ----------------------------------------------------------------------------
module apac_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [apac_pkg::NUM_W-1:0]    dividend,
  input  logic [apac_pkg::DIV_W-1:0]    divisor,
  output logic                          done,
  output logic [apac_pkg::NUM_W-1:0]    quo,
  output logic [apac_pkg::DIV_W-1:0]    rem
);

  logic [apac_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;
  logic [apac_pkg::NUM_W-1:0] quo_r, quo_nxt;
  logic [apac_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [apac_pkg::DIV_W-1:0] dvs_r, dvs_nxt;
  logic [apac_pkg::DIV_W:0]   trial;
  logic [apac_pkg::DIV_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[apac_pkg::NUM_W-1]};
    diff     = trial - {1'b0, dvs_r};
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = apac_pkg::CNT_W'(apac_pkg::NUM_W);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - apac_pkg::CNT_W'(1);
      done_nxt = (cnt_r == apac_pkg::CNT_W'(1));
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[apac_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[apac_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[apac_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[apac_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== src/apac_sum.sv =====
// ----------------------------------------------------------------------------
// apac_sum
// Proper divisor sum by trial division, one candidate per divider run.
// ----------------------------------------------------------------------------
module apac_sum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [apac_pkg::NUM_W-1:0]    value,
  output apac_pkg::unit_stat_t          stat,
  output logic [apac_pkg::SUM_W-1:0]    sum
);

  apac_pkg::sum_state_t         state_r, state_nxt;
  logic [apac_pkg::NUM_W-1:0]   val_r, val_nxt;
  logic [apac_pkg::DIV_W-1:0]   d_r, d_nxt;
  logic [apac_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic                         div_start;
  logic                         div_done;
  logic [apac_pkg::NUM_W-1:0]   quo;
  logic [apac_pkg::DIV_W-1:0]   rem;
  logic [apac_pkg::NUM_W-1:0]   d_ext;

  apac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (val_r),
    .divisor  (d_r),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  assign d_ext = {{(apac_pkg::NUM_W-apac_pkg::DIV_W){1'b0}}, d_r};

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    d_nxt     = d_r;
    sum_nxt   = sum_r;
    div_start = 1'b0;
    case (state_r)
      apac_pkg::SU_IDLE, apac_pkg::SU_FIN: begin
        state_nxt = apac_pkg::SU_IDLE;
        if (start) begin
          val_nxt = value;
          d_nxt   = apac_pkg::DIV_W'(2);
          if (value < apac_pkg::NUM_W'(2)) begin
            sum_nxt   = '0;
            state_nxt = apac_pkg::SU_FIN;
          end else begin
            sum_nxt   = apac_pkg::SUM_W'(1);
            state_nxt = apac_pkg::SU_LAUNCH;
          end
        end
      end
      apac_pkg::SU_LAUNCH: begin
        div_start = 1'b1;
        state_nxt = apac_pkg::SU_DIV;
      end
      apac_pkg::SU_DIV: begin
        if (div_done) begin
          if (d_ext > quo) begin
            state_nxt = apac_pkg::SU_FIN;
          end else if (rem == '0) begin
            sum_nxt = sum_r + apac_pkg::SUM_W'(d_r);
            if (quo != d_ext) begin
              state_nxt = apac_pkg::SU_ADDQ;
            end else begin
              d_nxt     = d_r + apac_pkg::DIV_W'(1);
              state_nxt = apac_pkg::SU_LAUNCH;
            end
          end else begin
            d_nxt     = d_r + apac_pkg::DIV_W'(1);
            state_nxt = apac_pkg::SU_LAUNCH;
          end
        end
      end
      apac_pkg::SU_ADDQ: begin
        sum_nxt   = sum_r + apac_pkg::SUM_W'(quo);
        d_nxt     = d_r + apac_pkg::DIV_W'(1);
        state_nxt = apac_pkg::SU_LAUNCH;
      end
      default: begin
        state_nxt = apac_pkg::SU_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apac_pkg::SU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    val_r <= val_nxt;
    d_r   <= d_nxt;
    sum_r <= sum_nxt;
  end

  assign stat.busy = (state_r != apac_pkg::SU_IDLE);
  assign stat.done = (state_r == apac_pkg::SU_FIN);
  assign sum       = sum_r;

endmodule

// ===== src/aliquot_perfect_amicable_check.sv =====
// ----------------------------------------------------------------------------
// aliquot_perfect_amicable_check
// Aliquot sum with perfect and amicable-low flags, bit-serial trial division.
// ----------------------------------------------------------------------------
// Channel  Ports                          Handshake
// in       in_number                      in_valid / in_ready
// out      out_aliquot_sum, out_is_*      out_valid / out_ready
// cfg      cfg_wdata (partner_limit)      cfg_we, no wait
//
// Each trial divisor takes one run of the bit-serial divider, which both passes
// share; a pass tries divisors up to about the square root of its number.
// The second pass runs only when n < s <= partner_limit.
// Synchronous active-low reset idles the core and sets partner_limit to all
// ones. One item is in work at a time; a finished result waits in the output
// register and the core holds until that register is free.
// ----------------------------------------------------------------------------
`include "aliquot_perfect_amicable_check_assert.svh"

module aliquot_perfect_amicable_check #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [apac_pkg::NUM_W-1:0]    in_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [apac_pkg::SUM_W-1:0]    out_aliquot_sum,
  output logic                          out_is_perfect,
  output logic                          out_is_amicable_low,
  input  logic                          cfg_we,
  input  logic [apac_pkg::NUM_W-1:0]    cfg_wdata
);

  localparam int NW_EFF = (NUMBER_WIDTH > apac_pkg::NUM_W) ? apac_pkg::NUM_W : NUMBER_WIDTH;

  apac_pkg::top_state_t         state_r, state_nxt;
  logic [NW_EFF-1:0]            num_r, num_nxt;
  logic [apac_pkg::SUM_W-1:0]   s1_r, s1_nxt;
  logic                         perf_r, perf_nxt;
  logic                         amic_r, amic_nxt;
  logic [apac_pkg::NUM_W-1:0]   limit_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [apac_pkg::SUM_W-1:0]   out_sum_r;
  logic                         out_perf_r;
  logic                         out_amic_r;
  logic                         out_load;
  logic [apac_pkg::NUM_W-1:0]   n_ext;
  logic [apac_pkg::NUM_W-1:0]   n_in;
  logic [apac_pkg::SUM_W-1:0]   n35;
  logic [apac_pkg::SUM_W-1:0]   lim35;
  logic                         sum_start;
  logic [apac_pkg::NUM_W-1:0]   sum_value;
  apac_pkg::unit_stat_t         sum_stat;
  logic [apac_pkg::SUM_W-1:0]   sum_res;

  apac_sum u_sum (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sum_start),
    .value (sum_value),
    .stat  (sum_stat),
    .sum   (sum_res)
  );

  always_comb begin
    n_ext              = '0;
    n_ext[NW_EFF-1:0]  = num_r;
    n_in               = '0;
    n_in[NW_EFF-1:0]   = in_number[NW_EFF-1:0];
    n35   = {{(apac_pkg::SUM_W-apac_pkg::NUM_W){1'b0}}, n_ext};
    lim35 = {{(apac_pkg::SUM_W-apac_pkg::NUM_W){1'b0}}, limit_r};
  end

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    s1_nxt        = s1_r;
    perf_nxt      = perf_r;
    amic_nxt      = amic_r;
    sum_start     = 1'b0;
    sum_value     = n_in;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      apac_pkg::T_IDLE: begin
        if (in_valid) begin
          num_nxt   = in_number[NW_EFF-1:0];
          sum_start = 1'b1;
          state_nxt = apac_pkg::T_PASS1;
        end
      end
      apac_pkg::T_PASS1: begin
        if (sum_stat.done) begin
          s1_nxt   = sum_res;
          perf_nxt = (sum_res == n35) && (n_ext > apac_pkg::NUM_W'(1));
          amic_nxt = 1'b0;
          if ((sum_res > n35) && (sum_res <= lim35)) begin
            sum_start = 1'b1;
            sum_value = sum_res[apac_pkg::NUM_W-1:0];
            state_nxt = apac_pkg::T_PASS2;
          end else begin
            state_nxt = apac_pkg::T_DONE;
          end
        end
      end
      apac_pkg::T_PASS2: begin
        if (sum_stat.done) begin
          amic_nxt  = (sum_res == n35);
          state_nxt = apac_pkg::T_DONE;
        end
      end
      apac_pkg::T_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = apac_pkg::T_IDLE;
        end
      end
      default: begin
        state_nxt = apac_pkg::T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apac_pkg::T_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= '1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
    num_r  <= num_nxt;
    s1_r   <= s1_nxt;
    perf_r <= perf_nxt;
    amic_r <= amic_nxt;
    if (out_load) begin
      out_sum_r  <= s1_r;
      out_perf_r <= perf_r;
      out_amic_r <= amic_r;
    end
  end

  assign in_ready            = (state_r == apac_pkg::T_IDLE);
  assign out_valid           = out_valid_r;
  assign out_aliquot_sum     = out_sum_r;
  assign out_is_perfect      = out_perf_r;
  assign out_is_amicable_low = out_amic_r;

  `APAC_ASSERT_IMP(a_idle_core, in_ready, !sum_stat.busy)
  `APAC_ASSERT_IMP(a_flag_excl, out_valid, !(out_is_perfect && out_is_amicable_low))
  `APAC_ASSERT_IMP(a_pass2_limit, state_r == apac_pkg::T_PASS2, s1_r <= lim35)
  `APAC_ASSERT_IMP(a_done_phase, sum_stat.done,
                   state_r == apac_pkg::T_PASS1 || state_r == apac_pkg::T_PASS2)

endmodule

// ===== sim/aliquot_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aliquot_result_checker
// Watches the number and result channels of the aliquot sum check. Works out
// the proper-divisor sum and the perfect and amicable-low flags of each
// accepted number, and compares each accepted result with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module aliquot_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [apac_pkg::NUM_W-1:0] in_number,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [apac_pkg::SUM_W-1:0] out_aliquot_sum,
  input  logic                       out_is_perfect,
  input  logic                       out_is_amicable_low,
  input  logic                       cfg_we,
  input  logic [apac_pkg::NUM_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         awaiting
);
  import apac_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             perfect;
    logic             amicable_low;
  } divisor_report_t;

  logic [NUM_W-1:0] partner_limit;
  divisor_report_t  reports_q[$];
  divisor_report_t  want;
  int               fail_cnt = 0;

  function automatic longint unsigned proper_sum(longint unsigned n);
    longint unsigned acc;
    longint unsigned d;
    if (n < 2) return 0;
    acc = 1;
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) begin
        acc += d;
        if (n / d != d) acc += n / d;
      end
    end
    return acc;
  endfunction

  function automatic divisor_report_t classify(logic [NUM_W-1:0] n, logic [NUM_W-1:0] cap);
    longint unsigned s;
    divisor_report_t r;
    s = proper_sum(n);
    r.sum = s[SUM_W-1:0];
    r.perfect = (n >= 2) && (s == n);
    r.amicable_low = (n >= 2) && (s > n) && (s <= cap) && (proper_sum(s) == n);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      partner_limit = '1;
      reports_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reports_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual sum %0d perfect %0b amicable %0b",
                   $time, out_aliquot_sum, out_is_perfect, out_is_amicable_low);
          fail_cnt++;
        end else begin
          want = reports_q.pop_front();
          if (out_aliquot_sum !== want.sum) begin
            $display("%0t: aliquot_sum mismatch, expected %0d, actual %0d",
                     $time, want.sum, out_aliquot_sum);
            fail_cnt++;
          end
          if (out_is_perfect !== want.perfect) begin
            $display("%0t: is_perfect mismatch, expected %0b, actual %0b",
                     $time, want.perfect, out_is_perfect);
            fail_cnt++;
          end
          if (out_is_amicable_low !== want.amicable_low) begin
            $display("%0t: is_amicable_low mismatch, expected %0b, actual %0b",
                     $time, want.amicable_low, out_is_amicable_low);
            fail_cnt++;
          end
        end
      end
      if (cfg_we) partner_limit = cfg_wdata;
      if (in_valid && in_ready) reports_q.push_back(classify(in_number, partner_limit));
    end
    mismatches <= fail_cnt;
    awaiting <= reports_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the aliquot sum check with directed numbers (small values, perfect
// numbers, squares, amicable pairs around the partner limit, the widest
// value) and then with random numbers under random partner limits, with
// random gaps and a long result stall. Results are checked by
// aliquot_result_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import apac_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [NUM_W-1:0] in_number;
  logic             out_valid;
  logic             out_ready;
  logic [SUM_W-1:0] out_aliquot_sum;
  logic             out_is_perfect;
  logic             out_is_amicable_low;
  logic             cfg_we;
  logic [NUM_W-1:0] cfg_wdata;
  int               mismatches;
  int               awaiting;
  bit               send_burst = 1'b0;

  logic [NUM_W-1:0] opening_numbers [0:18] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd12, 32'd28, 32'd49,
    32'd220, 32'd284, 32'd496, 32'd1184, 32'd8128, 32'd12285, 32'd66928,
    32'd65536, 32'hFFFF_FFFF
  };

  logic [NUM_W-1:0] notable_numbers [0:15] = '{
    32'd6, 32'd28, 32'd496, 32'd8128, 32'd220, 32'd284, 32'd1184, 32'd1210,
    32'd2620, 32'd2924, 32'd5020, 32'd5564, 32'd6232, 32'd6368, 32'd10744, 32'd10856
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  aliquot_perfect_amicable_check #(
    .NUMBER_WIDTH(32)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_number          (in_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_aliquot_sum    (out_aliquot_sum),
    .out_is_perfect     (out_is_perfect),
    .out_is_amicable_low(out_is_amicable_low),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  aliquot_result_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_number          (in_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_aliquot_sum    (out_aliquot_sum),
    .out_is_perfect     (out_is_perfect),
    .out_is_amicable_low(out_is_amicable_low),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .awaiting           (awaiting)
  );

  function automatic logic [NUM_W-1:0] pick_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return notable_numbers[$urandom_range(0, 15)];
    if (r < 85) return $urandom_range(2, 4095);
    if (r < 96) return $urandom_range(2, 65535);
    return $urandom_range(2, 32'h003F_FFFF);
  endfunction

  task automatic offer_number(input logic [NUM_W-1:0] n);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 11) == 0) send_burst = !send_burst;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_number <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [NUM_W-1:0] cap);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int gap;
    int taken;
    bit burst;
    taken = 0;
    burst = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 45) gap = 30000;
      else gap = burst ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 11) == 0) burst = !burst;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int phase;
    logic [NUM_W-1:0] cap;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_number <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening_numbers[i]) offer_number(opening_numbers[i]);
    settle();
    set_limit(32'd283);
    offer_number(32'd220);
    settle();
    set_limit(32'd284);
    offer_number(32'd220);
    offer_number(32'd1184);
    settle();
    set_limit(32'd2);
    offer_number(32'd220);
    offer_number(32'd6);
    offer_number(32'd284);
    for (phase = 0; phase < 4; phase++) begin
      settle();
      case (phase == 0 ? 0 : $urandom_range(0, 3))
        0: cap = '1;
        1: cap = $urandom_range(2, 32'hFFFF_FFFF);
        2: cap = $urandom_range(2, 20000);
        default: cap = 32'd2;
      endcase
      set_limit(cap);
      repeat (25) offer_number(pick_number());
    end
    settle();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
